// ===== design/ktl_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the keyword trie.
package ktl_pkg;

  // Node table size and alphabet
  localparam int MAX_NODES  = 128;
  localparam int ALPHABET   = 26;
  localparam int NODE_W     = $clog2(MAX_NODES);
  localparam int USED_W     = $clog2(MAX_NODES + 1);
  localparam int LINK_DEPTH = MAX_NODES * ALPHABET;
  localparam int LINK_AW    = $clog2(LINK_DEPTH);
  localparam int LETTER_W   = $clog2(ALPHABET);

  // Character codes
  localparam logic [7:0] CHAR_A = 8'h61;
  localparam logic [7:0] CHAR_Z = CHAR_A + 8'(ALPHABET - 1);

  // Word kinds
  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_INSERT = 1'b1;

  // Key failure codes, also the insert status codes
  typedef enum logic [1:0] {
    FAIL_NONE = 2'd0,
    FAIL_FULL = 2'd1,
    FAIL_BAD  = 2'd2
  } fail_t;

  // Controller to datapath
  typedef struct packed {
    logic clear;     // clear one child-link entry
    logic accept;    // take the input word, start child-link read
    logic walk;      // apply the link read, step the cursor
    logic load_out;  // load the result register
  } ktl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;  // last child-link entry being cleared
    logic item_end;  // word in flight ends its key
    logic out_free;  // result register can take a new word
  } ktl_stat_t;

endpackage

// ===== design/ktl_ctrl.sv =====
// Sequencer for the keyword trie: clearing pass, word accept, link step, result load.
module ktl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  ktl_pkg::ktl_stat_t st,
  output ktl_pkg::ktl_cmd_t  cmd
);
  import ktl_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LINK,
    S_RESULT
  } ctrl_state_t;

  ctrl_state_t state;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (st.clr_last) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) state <= S_LINK;
        end
        S_LINK: begin
          state <= st.item_end ? S_RESULT : S_IDLE;
        end
        S_RESULT: begin
          if (st.out_free) state <= S_IDLE;
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  // Commands
  always_comb begin
    cmd = '0;
    unique case (state)
      S_CLEAR:  cmd.clear    = 1'b1;
      S_IDLE:   cmd.accept   = in_valid;
      S_LINK:   cmd.walk     = 1'b1;
      S_RESULT: cmd.load_out = st.out_free;
      default:  cmd = '0;
    endcase
  end

  assign in_stall = (state != S_IDLE);

endmodule

// ===== design/ktl_datapath.sv =====
// Trie storage, cursor, allocator and result register.
module ktl_datapath (
  input  logic              clk,
  input  logic              rst,
  input  ktl_pkg::ktl_cmd_t  cmd,
  output ktl_pkg::ktl_stat_t st,
  input  logic              kind,
  input  logic [7:0]        char_code,
  input  logic              key_end,
  input  logic [7:0]        key_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              found,
  output logic [7:0]        match_value,
  output logic [1:0]        insert_status
);
  import ktl_pkg::*;

  // Storage
  logic [NODE_W-1:0] links [LINK_DEPTH];
  logic [7:0]        values [MAX_NODES];
  logic [MAX_NODES-1:0] node_valid;

  // Walk state
  logic [NODE_W-1:0]  cur_node;
  logic [USED_W-1:0]  nodes_used;
  fail_t              key_failed;
  logic [LINK_AW-1:0] clr_cnt;

  // Word in flight
  logic               it_insert;
  logic               it_end;
  logic               it_bad;
  logic [7:0]         it_value;
  logic [LINK_AW-1:0] slot_addr;
  logic [NODE_W-1:0]  link_rdata;

  // Pending result
  logic               res_insert;
  logic               res_hit;
  fail_t              res_status;
  logic [7:0]         val_rdata;

  // Combinational step
  logic [7:0]         letter_diff;
  logic               char_bad;
  logic [LINK_AW-1:0] slot_calc;
  logic [NODE_W-1:0]  cur_next;
  fail_t              fail_next;
  logic               alloc;
  logic [NODE_W-1:0]  child_new;
  logic               val_we;
  logic               val_re;
  logic               link_we;
  logic [LINK_AW-1:0] link_waddr;
  logic [NODE_W-1:0]  link_wdata;

  // Slot address of the incoming character
  assign letter_diff = char_code - CHAR_A;
  assign char_bad    = (char_code < CHAR_A) || (char_code > CHAR_Z);
  assign slot_calc   = LINK_AW'(cur_node) * LINK_AW'(ALPHABET)
                     + LINK_AW'(letter_diff[LETTER_W-1:0]);

  // One trie step from the link read
  assign child_new = nodes_used[NODE_W-1:0];
  always_comb begin
    fail_next = key_failed;
    cur_next  = cur_node;
    alloc     = 1'b0;
    if (key_failed == FAIL_NONE) begin
      if (it_bad) begin
        fail_next = FAIL_BAD;
      end else if (link_rdata != '0) begin
        cur_next = link_rdata;
      end else if (it_insert != KIND_INSERT) begin
        fail_next = FAIL_BAD;
      end else if (nodes_used == USED_W'(MAX_NODES)) begin
        fail_next = FAIL_FULL;
      end else begin
        alloc    = 1'b1;
        cur_next = child_new;
      end
    end
  end

  assign val_we = cmd.walk && it_end && (it_insert == KIND_INSERT) && (fail_next == FAIL_NONE);
  assign val_re = cmd.walk && it_end && (it_insert == KIND_LOOKUP);

  // Child-link write port: clearing pass or new child
  assign link_we    = cmd.clear || (cmd.walk && alloc);
  assign link_waddr = cmd.clear ? clr_cnt : slot_addr;
  assign link_wdata = cmd.clear ? '0 : child_new;

  always_ff @(posedge clk) begin
    if (link_we) links[link_waddr] <= link_wdata;
    if (cmd.accept) link_rdata <= links[slot_calc];
  end

  always_ff @(posedge clk) begin
    if (val_we) values[cur_next] <= it_value;
    if (val_re) val_rdata <= values[cur_next];
  end

  // Clearing counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // Capture the word
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      it_insert <= kind;
      it_end    <= key_end;
      it_bad    <= char_bad;
      it_value  <= key_value;
      slot_addr <= slot_calc;
    end
  end

  // Cursor, failure code, allocator and valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_node   <= '0;
      key_failed <= FAIL_NONE;
      nodes_used <= USED_W'(1);
      node_valid <= '0;
    end else if (cmd.walk) begin
      if (alloc) nodes_used <= nodes_used + 1'b1;
      // a new node starts empty unless this word stores its value
      if (val_we) begin
        node_valid[cur_next] <= 1'b1;
      end else if (alloc) begin
        node_valid[child_new] <= 1'b0;
      end
      if (it_end) begin
        cur_node   <= '0;
        key_failed <= FAIL_NONE;
      end else begin
        cur_node   <= cur_next;
        key_failed <= fail_next;
      end
    end
  end

  // Pending result fields
  always_ff @(posedge clk) begin
    if (cmd.walk && it_end) begin
      res_insert <= it_insert;
      res_status <= fail_next;
      res_hit    <= (fail_next == FAIL_NONE) && node_valid[cur_next];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      found         <= (res_insert == KIND_LOOKUP) && res_hit;
      match_value   <= ((res_insert == KIND_LOOKUP) && res_hit) ? val_rdata : 8'd0;
      insert_status <= (res_insert == KIND_INSERT) ? res_status : FAIL_NONE;
    end
  end

  assign st.clr_last = (clr_cnt == LINK_AW'(LINK_DEPTH - 1));
  assign st.item_end = it_end;
  assign st.out_free = !out_valid || !out_stall;

  // Checks
  a_used_range: assert property (@(posedge clk) disable iff (rst)
    (nodes_used != '0) && (nodes_used <= USED_W'(MAX_NODES)))
    else $error("node count out of range");

  a_cursor_alloc: assert property (@(posedge clk) disable iff (rst)
    USED_W'(cur_node) < nodes_used)
    else $error("cursor on unallocated node");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || !out_stall))
    else $error("result overwritten while held");

  a_insert_no_hit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && insert_status != FAIL_NONE) |-> (!found && match_value == 8'd0))
    else $error("insert result carries lookup fields");

  a_alloc_walk: assert property (@(posedge clk) disable iff (rst)
    (cmd.walk && alloc) |=> (nodes_used == $past(nodes_used) + 1'b1))
    else $error("allocation did not advance node count");

endmodule

// ===== design/keyword_trie_lookup.sv =====
// Top level of the 26-way keyword trie: sequencer plus trie datapath.
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------
//  input   | in_valid / in_stall   | kind, char_code, key_end, key_value
//  output  | out_valid / out_stall | found, match_value, insert_status
//
// A character word is accepted with its child-link read, then the link step is applied.
// A word that ends its key then loads the result register, once that register
// is no longer held by out_stall.
// The two-step loop is set by the registered read of the single child-link memory.
// After reset the child-link memory is cleared, all 3328 entries, with in_stall high.
// in_stall is high whenever a word is in flight.
module keyword_trie_lookup (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       kind,
  input  logic [7:0] char_code,
  input  logic       key_end,
  input  logic [7:0] key_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       found,
  output logic [7:0] match_value,
  output logic [1:0] insert_status
);
  import ktl_pkg::*;

  ktl_cmd_t  cmd;
  ktl_stat_t st;

  ktl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  ktl_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .kind          (kind),
    .char_code     (char_code),
    .key_end       (key_end),
    .key_value     (key_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .found         (found),
    .match_value   (match_value),
    .insert_status (insert_status)
  );

endmodule
